// ===== sv/fta_pkg.sv =====
// ----------------------------------------------------------------------------
// fta_pkg
// shared types and codes of the frame table allocator
// ----------------------------------------------------------------------------
package fta_pkg;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SIZE,
    S_FIT,
    S_CLAIM,
    S_REL,
    S_XLAT,
    S_HEAP,
    S_HWR,
    S_DONE
  } state_t;

  localparam logic [1:0] KIND_NEW  = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_XLAT = 2'd2;
  localparam logic [1:0] KIND_HEAP = 2'd3;

  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] REG_FRAME_LOG2  = 2'd1;
  localparam logic [1:0] REG_RESERVED    = 2'd2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

endpackage

// ===== sv/frame_table_allocator.sv =====
// ----------------------------------------------------------------------------
// frame_table_allocator
// inverted page table with first-fit frame allocation, one table ram
// ----------------------------------------------------------------------------
//  channel | dir | tdata / tuser
//  in_     | in  | tuser: kind; tdata: pid, size_bytes, stack_pages, page, byte_offset
//  out_    | out | tdata: ok, frame, address, page_count
//  cfg_    | in  | apb registers frame_count (0x0), frame_size_log2 (0x4),
//          |     | reserved_frames (0x8)
//
// every operation walks the table ram one entry per cycle through its single
// read port: free/translate/heap walk it at most once, a new process up to two
// fit walks and a release walk plus the claims (one write per page).
// after reset a clearing pass writes every table entry with in_tready low.
// the result waits in an output register; a new transaction is taken while it
// waits, and the block stalls only at the end of the next operation.
module frame_table_allocator #(
  parameter int FRAMES   = 256,
  parameter int PID_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pid[15:0], size_bytes[36:16], stack_pages[45:37], page[53:46],
  // byte_offset[65:54], zero pad
  input  logic [fta_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // ok[0], frame[8:1], address[28:9], page_count[37:29], zero pad
  output logic [fta_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [3:0]                       cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import fta_pkg::*;

  localparam int AW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int EW = 1 + PID_BITS + 8;

  // configuration
  logic [8:0] frame_count_r;
  logic [3:0] frame_log2_r;
  logic [8:0] reserved_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= 9'd256;
      frame_log2_r  <= 4'd8;
      reserved_r    <= 9'd12;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FRAME_COUNT: frame_count_r <= cfg_pwdata[8:0];
        REG_FRAME_LOG2:  frame_log2_r  <= cfg_pwdata[3:0];
        REG_RESERVED:    reserved_r    <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FRAME_COUNT: cfg_prdata = 32'(frame_count_r);
      REG_FRAME_LOG2:  cfg_prdata = 32'(frame_log2_r);
      REG_RESERVED:    cfg_prdata = 32'(reserved_r);
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // state and transaction fields
  state_t state_r, state_nxt;
  logic [PID_BITS-1:0] pid_r;
  logic [20:0]         size_r;
  logic [8:0]          stack_r;
  logic [7:0]          page_r;
  logic [11:0]         offs_r;
  logic                phase_r;
  logic [21:0]         code_r;
  logic [21:0]         fit_n_r;
  logic [AW-1:0]       start_r;
  logic [AW-1:0]       cstart_r;

  // scan machinery
  logic [CW-1:0] scan_a_r;
  logic          vld_r;
  logic [AW-1:0] pa_r;
  logic [CW-1:0] run_r;
  logic [CW-1:0] claim_j_r;
  logic [CW-1:0] hcnt_r;
  logic          hfound_r;
  logic [AW-1:0] hframe_r;

  // result
  logic          res_ok_r;
  logic [AW-1:0] res_frame_r;
  logic [8:0]    res_pc_r;
  logic          res_off_en_r;
  logic          out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  fta_ram #(
    .WIDTH (EW),
    .DEPTH (FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_a_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  logic                rd_used;
  logic [PID_BITS-1:0] rd_owner;
  logic [7:0]          rd_page;
  assign rd_used  = ram_rdata[EW-1];
  assign rd_owner = ram_rdata[8 +: PID_BITS];
  assign rd_page  = ram_rdata[7:0];

  logic [CW-1:0] cnt;
  logic          scan_issue, scan_end, in_range, free_v, owned_v;
  logic          fit_zero, fit_hit, fit_found, xlat_hit, claim_done, in_acc;
  logic [AW-1:0] fit_start;
  logic [21:0]   code_calc, size_mask;
  logic [7:0]    first_page;

  assign cnt = (32'(frame_count_r) < FRAMES) ? CW'(frame_count_r) : CW'(FRAMES);
  assign scan_issue = 32'(scan_a_r) < 32'(cnt);
  assign scan_end   = !vld_r && !scan_issue;
  assign in_range   = 32'(pa_r) >= 32'(reserved_r);
  assign free_v     = vld_r && in_range && !rd_used;
  assign owned_v    = vld_r && in_range && rd_used && (rd_owner == pid_r);
  assign fit_zero   = (fit_n_r == 22'd0);
  assign fit_hit    = free_v && ((22'(run_r) + 22'd1) == fit_n_r);
  assign fit_start  = pa_r - AW'(run_r);
  assign fit_found  = fit_zero ? (cnt != '0) : fit_hit;
  assign xlat_hit   = owned_v && (rd_page == page_r);
  assign claim_done = (22'(claim_j_r) == fit_n_r);
  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign first_page = phase_r ? code_r[7:0] : 8'd0;

  assign size_mask = (22'd1 << frame_log2_r) - 22'd1;
  assign code_calc = (22'(size_r) >> frame_log2_r) +
                     22'(((22'(size_r) & size_mask) != 22'd0));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (32'(scan_a_r) == FRAMES - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            KIND_NEW:  state_nxt = S_SIZE;
            KIND_FREE: state_nxt = S_REL;
            KIND_XLAT: state_nxt = S_XLAT;
            KIND_HEAP: state_nxt = S_HEAP;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_SIZE: state_nxt = S_FIT;
      S_FIT: begin
        if (fit_found) state_nxt = S_CLAIM;
        else if (fit_zero || scan_end) state_nxt = phase_r ? S_REL : S_DONE;
      end
      S_CLAIM: begin
        if (claim_done) state_nxt = phase_r ? S_DONE : S_FIT;
      end
      S_REL: begin
        if (scan_end) state_nxt = S_DONE;
      end
      S_XLAT: begin
        if (xlat_hit || scan_end) state_nxt = S_DONE;
      end
      S_HEAP: begin
        if (scan_end) state_nxt = hfound_r ? S_HWR : S_DONE;
      end
      S_HWR: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // ram write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pa_r;
    ram_wdata = {1'b0, rd_owner, rd_page};
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_a_r[AW-1:0];
        ram_wdata = '0;
      end
      S_CLAIM: begin
        ram_we    = !claim_done;
        ram_waddr = start_r + AW'(claim_j_r);
        ram_wdata = {1'b1, pid_r, first_page + 8'(claim_j_r)};
      end
      S_REL: begin
        ram_we = owned_v;
      end
      S_HWR: begin
        // page number is the owned count before the add
        ram_we    = 1'b1;
        ram_waddr = hframe_r;
        ram_wdata = {1'b1, pid_r, 8'(res_pc_r - 9'd1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      scan_a_r  <= '0;
      vld_r     <= 1'b0;
      hfound_r  <= 1'b0;
      claim_j_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) begin
        scan_a_r  <= '0;
        vld_r     <= 1'b0;
        run_r     <= '0;
        claim_j_r <= '0;
        hcnt_r    <= '0;
        hfound_r  <= 1'b0;
      end else begin
        unique case (state_r)
          S_CLR:   scan_a_r  <= scan_a_r + CW'(1);
          S_CLAIM: claim_j_r <= claim_j_r + CW'(1);
          S_FIT, S_REL, S_XLAT, S_HEAP: begin
            if (scan_issue) scan_a_r <= scan_a_r + CW'(1);
            vld_r <= scan_issue;
            pa_r  <= scan_a_r[AW-1:0];
            if (vld_r) begin
              run_r <= free_v ? run_r + CW'(1) : '0;
              if (owned_v) hcnt_r <= hcnt_r + CW'(1);
              if (free_v && !hfound_r) begin
                hfound_r <= 1'b1;
                hframe_r <= pa_r;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // transaction and result registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pid_r        <= PID_BITS'(in_tdata[15:0]);
          size_r       <= in_tdata[36:16];
          stack_r      <= in_tdata[45:37];
          page_r       <= in_tdata[53:46];
          offs_r       <= in_tdata[65:54];
          phase_r      <= 1'b0;
          res_ok_r     <= (in_tuser == KIND_FREE);
          res_frame_r  <= '0;
          res_pc_r     <= '0;
          res_off_en_r <= 1'b0;
        end
      end
      S_SIZE: begin
        code_r  <= code_calc;
        fit_n_r <= code_calc;
      end
      S_FIT: begin
        if (fit_found) begin
          start_r <= fit_zero ? '0 : fit_start;
          if (!phase_r) cstart_r <= fit_zero ? '0 : fit_start;
        end
      end
      S_CLAIM: begin
        if (claim_done) begin
          if (!phase_r) begin
            phase_r <= 1'b1;
            fit_n_r <= 22'(stack_r);
          end else begin
            res_ok_r    <= 1'b1;
            res_frame_r <= cstart_r;
            res_pc_r    <= 9'(code_r + 22'(stack_r));
          end
        end
      end
      S_XLAT: begin
        if (xlat_hit) begin
          res_ok_r     <= 1'b1;
          res_frame_r  <= pa_r;
          res_off_en_r <= 1'b1;
        end
      end
      S_HEAP: begin
        if (scan_end && hfound_r) begin
          res_ok_r    <= 1'b1;
          res_frame_r <= hframe_r;
          res_pc_r    <= 9'(32'(hcnt_r) + 1);
        end
      end
      default: ;
    endcase
  end

  // output register
  logic [31:0] base_w;
  logic [19:0] addr_w;
  assign base_w = 32'(res_frame_r) << frame_log2_r;
  assign addr_w = res_ok_r ? (base_w[19:0] + (res_off_en_r ? 20'(offs_r) : 20'd0)) : 20'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
      out_data_r  <= {2'b00, res_pc_r, addr_w, 8'(res_frame_r), res_ok_r};
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted transaction did not start an operation");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (!in_tready && ram_we))
    else $error("clearing pass not exclusive");

  a_heap_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HWR) |-> (ram_we && ram_wdata[EW-1] && res_ok_r))
    else $error("heap claim without success");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ok_r) |-> (res_frame_r == '0 && res_pc_r == 9'd0))
    else $error("failure result carries data");

endmodule

// ===== sv/fta_ram.sv =====
// ----------------------------------------------------------------------------
// fta_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module fta_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== dv/frame_table_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// frame_table_allocator_tb
// drives directed and random table operations through the stream ports under
// several register settings and checks every result against an in-bench model
// ----------------------------------------------------------------------------
module frame_table_allocator_tb;
  import fta_pkg::*;

  localparam int NFR = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pid;
    logic [20:0] size_bytes;
    logic [8:0]  stack_pages;
    logic [7:0]  page;
    logic [11:0] byte_offset;
  } op_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  frame;
    logic [19:0] address;
    logic [8:0]  page_count;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  frame_table_allocator dut (.*);

  // table model
  logic [8:0]  m_count = 256;
  logic [3:0]  m_log2 = 8;
  logic [8:0]  m_resv = 12;
  bit          m_used [NFR];
  logic [15:0] m_owner [NFR];
  logic [7:0]  m_page [NFR];

  res_t pending_results[$];
  int   errors = 0;
  int   n_sent = 0, n_recv = 0, n_ok = 0;
  int   send_idle = 0, recv_idle = 0;
  bit   hold_recv = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #150000000;
    $display("timeout at %0t", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int eff_count();
    return (m_count < NFR) ? int'(m_count) : NFR;
  endfunction

  function automatic bit frame_free(int i);
    return i >= m_resv && i < eff_count() && !m_used[i];
  endfunction

  function automatic bit frame_owned(int i, logic [15:0] pid);
    return i >= m_resv && i < eff_count() && m_used[i] && m_owner[i] == pid;
  endfunction

  function automatic bit find_run(int n, output int start);
    int cnt;
    bit fits;
    cnt = eff_count();
    start = 0;
    for (int i = 0; i < cnt; i++) begin
      fits = (i + n) <= cnt;
      for (int j = 0; fits && j < n; j++)
        if (!frame_free(i + j)) fits = 0;
      if (fits) begin
        start = i;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic void take_run(int start, int n, logic [15:0] pid, int first);
    for (int j = 0; j < n; j++) begin
      m_used[start + j] = 1;
      m_owner[start + j] = pid;
      m_page[start + j] = 8'(first + j);
    end
  endfunction

  function automatic void drop_pid(logic [15:0] pid);
    for (int i = 0; i < NFR; i++)
      if (frame_owned(i, pid)) m_used[i] = 0;
  endfunction

  function automatic int pages_of(logic [15:0] pid);
    int c = 0;
    for (int i = 0; i < NFR; i++)
      if (frame_owned(i, pid)) c++;
    return c;
  endfunction

  function automatic logic [19:0] frame_base(int f);
    logic [31:0] b;
    b = 32'(f) << m_log2;
    return b[19:0];
  endfunction

  function automatic res_t table_apply(op_t t);
    res_t r;
    int code, cs, ss, f;
    logic [31:0] sz;
    r = '0;
    case (t.kind)
      KIND_NEW: begin
        sz = 32'(t.size_bytes);
        code = int'(sz >> m_log2) + (((sz & ((32'd1 << m_log2) - 1)) != 0) ? 1 : 0);
        if (find_run(code, cs)) begin
          take_run(cs, code, t.pid, 0);
          if (find_run(int'(t.stack_pages), ss)) begin
            take_run(ss, int'(t.stack_pages), t.pid, code);
            r.ok = 1;
            r.frame = 8'(cs);
            r.address = frame_base(cs);
            r.page_count = 9'(code + int'(t.stack_pages));
          end else begin
            drop_pid(t.pid);
          end
        end
      end
      KIND_FREE: begin
        drop_pid(t.pid);
        r.ok = 1;
      end
      KIND_XLAT: begin
        for (int i = 0; i < NFR; i++)
          if (frame_owned(i, t.pid) && m_page[i] == t.page) begin
            r.ok = 1;
            r.frame = 8'(i);
            r.address = frame_base(i) + 20'(t.byte_offset);
            break;
          end
      end
      default: begin
        if (find_run(1, f)) begin
          take_run(f, 1, t.pid, pages_of(t.pid));
          r.ok = 1;
          r.frame = 8'(f);
          r.address = frame_base(f);
          r.page_count = 9'(pages_of(t.pid));
        end
      end
    endcase
    return r;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      REG_FRAME_COUNT: m_count = val[8:0];
      REG_FRAME_LOG2:  m_log2 = val[3:0];
      default:         m_resv = val[8:0];
    endcase
  endtask

  // sender: checks tready at the edge, predicts on acceptance
  task automatic send_op(op_t t, bit has_want = 0, res_t want = '0);
    res_t r;
    @(posedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
    in_tvalid <= 1;
    in_tuser <= t.kind;
    in_tdata <= IN_TDATA_W'({t.byte_offset, t.page, t.stack_pages, t.size_bytes, t.pid});
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 0;
    r = table_apply(t);
    if (has_want && r !== want) begin
      $display("%0t directed row table mismatch: typed %h model %h", $time, want, r);
      errors++;
    end
    pending_results.push_back(r);
    n_sent++;
  endtask

  task automatic drain();
    int guard = 0;
    while (pending_results.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (1200) @(posedge clk);
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        res_t got, exp;
        got = {out_tdata[0], out_tdata[8:1], out_tdata[28:9], out_tdata[37:29]};
        n_recv++;
        if (pending_results.size() == 0) begin
          $display("%0t unexpected transaction %h", $time, got);
          errors++;
        end else begin
          exp = pending_results.pop_front();
          if (got.ok !== exp.ok || got.frame !== exp.frame ||
              got.address !== exp.address || got.page_count !== exp.page_count) begin
            $display("%0t mismatch exp ok=%0d fr=%0d ad=%h pc=%0d got ok=%0d fr=%0d ad=%h pc=%0d",
                     $time, exp.ok, exp.frame, exp.address, exp.page_count,
                     got.ok, got.frame, got.address, got.page_count);
            errors++;
          end
          if (exp.ok) n_ok++;
        end
      end
      out_tready <= !hold_recv && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  // pids kept in a small pool so translate and free hit live processes
  function automatic logic [15:0] pick_pid();
    return ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(7));
  endfunction

  function automatic op_t rand_op();
    op_t t;
    t.kind = 2'($urandom_range(3));
    t.pid = pick_pid();
    case ($urandom_range(9))
      0: t.size_bytes = 21'($urandom);
      1: t.size_bytes = 21'h100000;
      default: t.size_bytes = 21'($urandom_range(1, 4096));
    endcase
    t.stack_pages = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(4));
    t.page = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(7));
    t.byte_offset = 12'($urandom);
    return t;
  endfunction

  op_t  dir_ops [$];
  res_t dir_res [$];
  bit   dir_has [$];

  task automatic add_row(logic [1:0] k, logic [15:0] p, logic [20:0] s, logic [8:0] st,
                         logic [7:0] pg, logic [11:0] off, bit has, res_t r);
    dir_ops.push_back('{k, p, s, st, pg, off});
    dir_has.push_back(has);
    dir_res.push_back(r);
  endtask

  initial begin
    op_t t;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // directed table, reset settings: 256 frames of 256 bytes, 12 reserved
    add_row(KIND_XLAT, 16'd1, 21'd1, 9'd0, 8'd0, 12'd5, 1, '{0, 8'd0, 20'd0, 9'd0});
    add_row(KIND_NEW, 16'd1, 21'd1, 9'd1, 8'd0, 12'd0, 1, '{1, 8'd12, 20'hC00, 9'd2});
    add_row(KIND_XLAT, 16'd1, 21'd0, 9'd0, 8'd0, 12'hFFF, 1, '{1, 8'd12, 20'h1BFF, 9'd0});
    add_row(KIND_XLAT, 16'd1, 21'd0, 9'd0, 8'd1, 12'd0, 0, '0);
    add_row(KIND_HEAP, 16'd1, 21'd0, 9'd0, 8'd0, 12'd0, 0, '0);
    add_row(KIND_NEW, 16'hFFFF, 21'h1FFFFF, 9'd0, 8'd0, 12'd0, 1, '0);
    add_row(KIND_NEW, 16'd2, 21'd1024, 9'd511, 8'd0, 12'd0, 1, '0);
    add_row(KIND_NEW, 16'd1, 21'd256, 9'd256, 8'd0, 12'd0, 1, '0);
    add_row(KIND_XLAT, 16'd1, 21'd0, 9'd0, 8'd0, 12'd0, 1, '0);
    add_row(KIND_NEW, 16'd3, 21'd0, 9'd0, 8'd0, 12'd0, 0, '0);
    add_row(KIND_NEW, 16'd4, 21'd512, 9'd2, 8'd0, 12'd0, 0, '0);
    add_row(KIND_HEAP, 16'd4, 21'd0, 9'd0, 8'd0, 12'd0, 0, '0);
    add_row(KIND_XLAT, 16'd4, 21'd0, 9'd0, 8'd4, 12'd7, 0, '0);
    add_row(KIND_FREE, 16'd9, 21'd0, 9'd0, 8'hFF, 12'd0, 1, '{1, 8'd0, 20'd0, 9'd0});
    add_row(KIND_FREE, 16'd4, 21'h1FFFFF, 9'h1FF, 8'hFF, 12'hFFF, 1, '{1, 8'd0, 20'd0, 9'd0});
    add_row(KIND_NEW, 16'd5, 21'h100000, 9'd0, 8'd0, 12'd0, 0, '0);
    for (int i = 0; i < dir_ops.size(); i++) send_op(dir_ops[i], dir_has[i], dir_res[i]);
    drain();

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin reg_write(REG_FRAME_COUNT, 32'd1); reg_write(REG_RESERVED, 32'd0);
                 reg_write(REG_FRAME_LOG2, 32'd4); end
        1: begin reg_write(REG_FRAME_COUNT, 32'd40); reg_write(REG_FRAME_LOG2, 32'd12); end
        2: begin reg_write(REG_FRAME_COUNT, 32'h1FF); reg_write(REG_RESERVED, 32'd256); end
        3: begin reg_write(REG_FRAME_COUNT, 32'd64); reg_write(REG_RESERVED, 32'd3);
                 reg_write(REG_FRAME_LOG2, 32'd0); end
        4: begin reg_write(REG_FRAME_COUNT, 32'd256); reg_write(REG_FRAME_LOG2, 32'd15); end
        5: begin reg_write(REG_FRAME_LOG2, 32'hFFFFFFF9); reg_write(REG_RESERVED, 32'd12); end
        6: begin reg_write(REG_FRAME_COUNT, 32'd32); reg_write(REG_RESERVED, 32'd8); end
        default: begin reg_write(REG_FRAME_COUNT, 32'd256); reg_write(REG_FRAME_LOG2, 32'd8); end
      endcase
      send_idle = (ph < 3) ? 33 : (ph < 6) ? 47 : 0;
      recv_idle = (ph < 3) ? 47 : (ph < 6) ? 33 : 0;
      if (ph == 6) begin
        // long receiver hold while the sender keeps offering
        fork
          begin hold_recv = 1; repeat (3000) @(posedge clk); hold_recv = 0; end
          for (int k = 0; k < 10; k++) send_op(rand_op());
        join
      end
      for (int k = 0; k < 137; k++) begin
        t = rand_op();
        send_op(t);
        // sender waits out every open transaction now and then
        if (k == 70)
          while (pending_results.size() != 0) @(posedge clk);
      end
      drain();
    end

    $display("covered %0d transactions over 9 register settings, %0d succeeded", n_sent, n_ok);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures, %0d results outstanding", errors, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
